>>> sv/hs_pkg.sv
// Shared constants and types for the histogram statistics block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package hs_pkg;

    localparam int HS_MAX_BINS = 256;
    localparam int W_W         = 17;
    localparam int FRAC_W      = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [W_W-1:0] FRAC_ONE  = 17'h10000;
    localparam logic [W_W-1:0] THR_RESET = 17'h08000;

    // Register index taken from paddr[APB_AW-1:2]
    localparam logic REG_THRESHOLD = 1'b0;

    typedef enum logic [2:0] {
        OP_MEAN   = 3'd0,
        OP_MEDIAN = 3'd1,
        OP_STD    = 3'd2,
        OP_LOW    = 3'd3,
        OP_HIGH   = 3'd4
    } div_op_t;

endpackage

>>> sv/hs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_div
    import hs_pkg::*;
#(
    parameter int NW = 33,
    parameter int DW = 17
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CNW = $clog2(NW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;

    logic [DW:0] rem_sh;
    logic [DW:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            q_reg   <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> sv/hs_sqrt.sv
// Integer square root, one root bit per cycle (restoring form).
// Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_sqrt
    import hs_pkg::*;
#(
    parameter int TW = 91,
    localparam int TE = TW + (TW % 2),
    localparam int RW = TE / 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW-1:0] radicand,
    output logic          done,
    output logic [RW-1:0] root
);

    localparam int CNW = $clog2(RW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [TE-1:0]  t_sh_reg;
    logic [RW:0]    rem_reg;
    logic [RW-1:0]  root_reg;

    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    assign rem_sh = {rem_reg, t_sh_reg[TE-1:TE-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            t_sh_reg <= TE'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            t_sh_reg <= {t_sh_reg[TE-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW:0] : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/hs_var.sv
// Bin store and variance pass: sum of w*(i*2^16 - S)^2 over stored bins,
// using a shift-add multiplier. Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_var
    import hs_pkg::*;
#(
    parameter int MAX_BINS = HS_MAX_BINS,
    localparam int IW = $clog2(MAX_BINS),
    localparam int CW = $clog2(MAX_BINS + 1),
    localparam int SW = W_W + 2 * IW,
    localparam int TW = IW + W_W + 2 * SW
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [IW-1:0]  wr_addr,
    input  logic [W_W-1:0] wr_data,
    input  logic           start,
    input  logic [CW-1:0]  bin_count,
    input  logic [SW-1:0]  index_sum,
    output logic           done,
    output logic [TW-1:0]  var_sum
);

    localparam int PW = 2 * SW + W_W;

    typedef enum logic [4:0] {
        V_IDLE = 5'b00001,
        V_READ = 5'b00010,
        V_DIFF = 5'b00100,
        V_MUL  = 5'b01000,
        V_ACC  = 5'b10000
    } vstate_t;

    vstate_t        state_reg;
    logic           done_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  n_reg;
    logic [SW-1:0]  s_reg;
    logic [SW-1:0]  d_reg;
    logic [PW-1:0]  mcand_reg;
    logic [SW-1:0]  mplier_reg;
    logic [PW-1:0]  prod_reg;
    logic           second_reg;
    logic [TW-1:0]  t_reg;
    logic [W_W-1:0] rd_data_reg;

    logic [W_W-1:0] mem [MAX_BINS];

    logic [SW-1:0] pos;
    logic [SW-1:0] delta;
    logic [CW-1:0] idx_next;

    assign pos      = {{(SW - IW - FRAC_W){1'b0}}, idx_reg[IW-1:0], {FRAC_W{1'b0}}};
    assign delta    = (pos >= s_reg) ? (pos - s_reg) : (s_reg - pos);
    assign idx_next = idx_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= V_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                V_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= V_READ;
                    end
                end
                V_READ:
                begin
                    state_reg <= V_DIFF;
                end
                V_DIFF:
                begin
                    state_reg <= V_MUL;
                end
                V_MUL:
                begin
                    if (mplier_reg == '0 && second_reg)
                    begin
                        state_reg <= V_ACC;
                    end
                end
                V_ACC:
                begin
                    if (idx_next == n_reg)
                    begin
                        state_reg <= V_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= V_READ;
                    end
                end
                default:
                begin
                    state_reg <= V_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            V_IDLE:
            begin
                if (start)
                begin
                    n_reg   <= bin_count;
                    s_reg   <= index_sum;
                    idx_reg <= '0;
                    t_reg   <= '0;
                end
            end
            V_DIFF:
            begin
                d_reg      <= delta;
                mcand_reg  <= PW'(delta);
                mplier_reg <= SW'(rd_data_reg);
                prod_reg   <= '0;
                second_reg <= 1'b0;
            end
            V_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    // first product done: multiply it by the distance again
                    if (!second_reg)
                    begin
                        mcand_reg  <= prod_reg;
                        mplier_reg <= d_reg;
                        prod_reg   <= '0;
                        second_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SW-1:1]};
                end
            end
            V_ACC:
            begin
                t_reg   <= t_reg + TW'(prod_reg);
                idx_reg <= idx_next;
            end
            default:
            begin
            end
        endcase
    end

    assign done    = done_reg;
    assign var_sum = t_reg;

endmodule

>>> sv/histogram_statistics_top.sv
// Histogram statistics: bins stream in at one per cycle while the block is loading
// (bin_ready is low otherwise); the result follows the last bin after the variance
// pass over the stored bins, the square root and five serial divisions, then a
// write-back to the result register.
// One histogram in flight; loading the next may overlap a waiting result.
// rst_n clears all control state asynchronously; the bin store is not cleared.
`timescale 1ns / 1ps

module histogram_statistics_top
    import hs_pkg::*;
#(
    parameter int MAX_BINS = HS_MAX_BINS
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // bin stream
    input  logic              bin_valid,
    output logic              bin_ready,
    input  logic [W_W-1:0]    bin_weight,
    input  logic              last_bin,
    // result stream
    output logic              res_valid,
    input  logic              res_ready,
    output logic [W_W-1:0]    mean_frac,
    output logic [W_W-1:0]    median_frac,
    output logic              median_found,
    output logic [W_W-1:0]    stddev_frac,
    output logic [W_W-1:0]    low_bound_frac,
    output logic [W_W-1:0]    high_bound_frac,
    output logic              bounds_found,
    output logic              saturated
);

    localparam int IW   = $clog2(MAX_BINS);
    localparam int CW   = $clog2(MAX_BINS + 1);
    localparam int SW   = W_W + 2 * IW;
    localparam int RUNW = W_W + IW;
    localparam int TW   = IW + W_W + 2 * SW;
    localparam int TE   = TW + (TW % 2);
    localparam int RW   = TE / 2;
    localparam int NWD  = (SW > RW) ? SW : RW;
    localparam int DWD  = CW + 8;

    typedef enum logic [4:0] {
        S_LOAD = 5'b00001,
        S_VAR  = 5'b00010,
        S_SQRT = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } state_t;

    state_t          state_reg;
    logic [W_W-1:0]  thr_reg;
    logic [CW-1:0]   cnt_reg;
    logic [SW-1:0]   s_reg;
    logic [RUNW-1:0] run_reg;
    logic [IW-1:0]   med_idx_reg;
    logic            med_hit_reg;
    logic [IW-1:0]   first_reg;
    logic [IW-1:0]   last_idx_reg;
    logic            any_reg;
    logic            over_reg;
    logic            clip_reg;
    logic            var_start_reg;
    logic            div_start_reg;
    div_op_t         op_reg;
    logic [W_W-1:0]  mean_q_reg;
    logic [W_W-1:0]  med_q_reg;
    logic [W_W-1:0]  std_q_reg;
    logic [W_W-1:0]  low_q_reg;
    logic [W_W-1:0]  high_q_reg;
    logic            res_valid_reg;
    logic [W_W-1:0]  mean_out_reg;
    logic [W_W-1:0]  median_out_reg;
    logic            med_found_out_reg;
    logic [W_W-1:0]  std_out_reg;
    logic [W_W-1:0]  low_out_reg;
    logic [W_W-1:0]  high_out_reg;
    logic            bounds_out_reg;
    logic            sat_out_reg;

    logic              bin_accept;
    logic              have_room;
    logic [IW-1:0]     idx;
    logic [IW+W_W-1:0] iw_prod;
    logic [RUNW-1:0]   run_next;
    logic              cfg_write;
    logic              var_done;
    logic [TW-1:0]     var_sum;
    logic              sqrt_done;
    logic [RW-1:0]     root;
    logic              div_done;
    logic [NWD-1:0]    div_num;
    logic [DWD-1:0]    div_den;
    logic [NWD-1:0]    div_quot;
    logic              q_over;
    logic [W_W-1:0]    q_clip;
    logic              wb_fire;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_THRESHOLD);
    assign prdata    = (paddr[APB_AW-1:2] == REG_THRESHOLD) ? APB_DW'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= pwdata[W_W-1:0];
        end
    end

    // ---------------- bin loading ----------------
    // One bin per cycle while in S_LOAD; bins beyond capacity are dropped and flagged.
    assign bin_ready  = (state_reg == S_LOAD);
    assign bin_accept = bin_valid && bin_ready;
    assign have_room  = cnt_reg < CW'(MAX_BINS);
    assign idx        = cnt_reg[IW-1:0];
    assign iw_prod    = {{W_W{1'b0}}, idx} * {{IW{1'b0}}, bin_weight};
    assign run_next   = run_reg + RUNW'(bin_weight);

    // Write-back moves results to the output register once it is free.
    assign wb_fire = (state_reg == S_WB) && (!res_valid_reg || res_ready);

    // ---------------- divider operand select ----------------
    always_comb
    begin
        div_num = '0;
        div_den = DWD'(cnt_reg);
        case (op_reg)
            OP_MEAN:   div_num = NWD'(s_reg);
            OP_MEDIAN: div_num = NWD'({med_idx_reg, {FRAC_W{1'b0}}});
            OP_STD:
            begin
                div_num = NWD'(root);
                div_den = {cnt_reg, 8'h00};
            end
            OP_LOW:    div_num = NWD'({first_reg, {FRAC_W{1'b0}}});
            OP_HIGH:   div_num = NWD'({last_idx_reg, {FRAC_W{1'b0}}});
            default:   div_num = '0;
        endcase
    end

    // Clip quotients to 1.0
    assign q_over = div_quot > NWD'(FRAC_ONE);
    assign q_clip = q_over ? FRAC_ONE : div_quot[W_W-1:0];

    // ---------------- sequencer and accumulators ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            s_reg         <= '0;
            run_reg       <= '0;
            med_idx_reg   <= '0;
            med_hit_reg   <= 1'b0;
            first_reg     <= '0;
            last_idx_reg  <= '0;
            any_reg       <= 1'b0;
            over_reg      <= 1'b0;
            clip_reg      <= 1'b0;
            var_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            op_reg        <= OP_MEAN;
        end
        else
        begin
            var_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            case (state_reg)
                S_LOAD:
                begin
                    if (bin_accept)
                    begin
                        if (have_room)
                        begin
                            s_reg   <= s_reg + SW'(iw_prod);
                            run_reg <= run_next;
                            cnt_reg <= cnt_reg + 1'b1;
                            if (!med_hit_reg && (run_next >= RUNW'(thr_reg)))
                            begin
                                med_idx_reg <= idx;
                                med_hit_reg <= 1'b1;
                            end
                            if (bin_weight != '0)
                            begin
                                if (!any_reg)
                                begin
                                    first_reg <= idx;
                                    any_reg   <= 1'b1;
                                end
                                last_idx_reg <= idx;
                            end
                        end
                        else
                        begin
                            over_reg <= 1'b1;
                        end
                        if (last_bin)
                        begin
                            // accumulators settle at this edge; start pass next cycle
                            state_reg     <= S_VAR;
                            var_start_reg <= 1'b1;
                            op_reg        <= OP_MEAN;
                        end
                    end
                end
                S_VAR:
                begin
                    if (var_done)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        state_reg     <= S_DIV;
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if ((op_reg == OP_MEAN || op_reg == OP_STD) && q_over)
                        begin
                            clip_reg <= 1'b1;
                        end
                        if (op_reg == OP_HIGH)
                        begin
                            state_reg <= S_WB;
                        end
                        else
                        begin
                            op_reg        <= div_op_t'(op_reg + 3'd1);
                            div_start_reg <= 1'b1;
                        end
                    end
                end
                S_WB:
                begin
                    if (wb_fire)
                    begin
                        // clear for the next histogram
                        state_reg   <= S_LOAD;
                        cnt_reg     <= '0;
                        s_reg       <= '0;
                        run_reg     <= '0;
                        med_idx_reg <= '0;
                        med_hit_reg <= 1'b0;
                        first_reg   <= '0;
                        last_idx_reg <= '0;
                        any_reg     <= 1'b0;
                        over_reg    <= 1'b0;
                        clip_reg    <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Hold each quotient as its division completes
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            case (op_reg)
                OP_MEAN:   mean_q_reg <= q_clip;
                OP_MEDIAN: med_q_reg  <= q_clip;
                OP_STD:    std_q_reg  <= q_clip;
                OP_LOW:    low_q_reg  <= q_clip;
                OP_HIGH:   high_q_reg <= q_clip;
                default:   mean_q_reg <= mean_q_reg;
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            mean_out_reg      <= mean_q_reg;
            median_out_reg    <= med_hit_reg ? med_q_reg : '0;
            med_found_out_reg <= med_hit_reg;
            std_out_reg       <= std_q_reg;
            low_out_reg       <= any_reg ? low_q_reg : '0;
            high_out_reg      <= any_reg ? high_q_reg : '0;
            bounds_out_reg    <= any_reg;
            sat_out_reg       <= over_reg || clip_reg;
        end
    end

    assign res_valid       = res_valid_reg;
    assign mean_frac       = mean_out_reg;
    assign median_frac     = median_out_reg;
    assign median_found    = med_found_out_reg;
    assign stddev_frac     = std_out_reg;
    assign low_bound_frac  = low_out_reg;
    assign high_bound_frac = high_out_reg;
    assign bounds_found    = bounds_out_reg;
    assign saturated       = sat_out_reg;

    // ---------------- datapath units ----------------
    hs_var #(
        .MAX_BINS (MAX_BINS)
    ) u_var (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (bin_accept && have_room),
        .wr_addr   (idx),
        .wr_data   (bin_weight),
        .start     (var_start_reg),
        .bin_count (cnt_reg),
        .index_sum (s_reg),
        .done      (var_done),
        .var_sum   (var_sum)
    );

    hs_sqrt #(
        .TW (TW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (var_done),
        .radicand (var_sum),
        .done     (sqrt_done),
        .root     (root)
    );

    hs_div #(
        .NW (NWD),
        .DW (DWD)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_BINS))
        else $error("bin counter past capacity");

    a_var_start: assert property (@(posedge clk) disable iff (!rst_n)
        var_start_reg |-> state_reg == S_VAR)
        else $error("variance pass started outside its phase");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        any_reg |-> first_reg <= last_idx_reg)
        else $error("first non-zero bin after last non-zero bin");

    a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && res_valid_reg && !res_ready) |=> state_reg == S_WB)
        else $error("result written over an untaken transaction");

endmodule

>>> dv/histogram_statistics_top_tb.sv
// Self-checking testbench for histogram_statistics_top: bin stream in, one statistics
// transaction out per histogram, threshold register over APB. Depends on hs_pkg and the RTL.
`timescale 1ns / 1ps

module histogram_statistics_top_tb
    import hs_pkg::*;
();

    localparam int NBINS      = HS_MAX_BINS;
    localparam int WDOG_LIMIT = 200000;   // idle cycles
    localparam int SETTLE     = 40;       // cycles allowed after the last result

    typedef struct {
        logic [W_W-1:0] mean;
        logic [W_W-1:0] median;
        logic           median_ok;
        logic [W_W-1:0] stddev;
        logic [W_W-1:0] low_b;
        logic [W_W-1:0] high_b;
        logic           bounds_ok;
        logic           sat;
    } stats_t;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              bin_valid, bin_ready;
    logic [W_W-1:0]    bin_weight;
    logic              last_bin;
    logic              res_valid, res_ready;
    logic [W_W-1:0]    mean_frac, median_frac, stddev_frac, low_bound_frac, high_bound_frac;
    logic              median_found, bounds_found, saturated;

    histogram_statistics_top dut (.*);

    // Shadow copy of the block's histogram state
    logic [W_W-1:0] shadow_bins [NBINS];
    int unsigned    shadow_count;
    logic [63:0]    shadow_wsum;
    logic [63:0]    shadow_runw;
    int unsigned    shadow_median_idx;
    logic           shadow_median_hit;
    int unsigned    shadow_first_nz;
    int unsigned    shadow_last_nz;
    logic           shadow_any_nz;
    logic           shadow_overflow;
    logic [W_W-1:0] shadow_threshold;

    stats_t pending_stats[$];
    int     mismatches;
    int     items_sent;
    int     idle_cycles;
    bit     bin_burst;    // when set, the sender never idles
    bit     res_burst;    // when set, the receiver never stalls

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_shadow();
        shadow_count      = 0;
        shadow_wsum       = '0;
        shadow_runw       = '0;
        shadow_median_idx = 0;
        shadow_median_hit = 1'b0;
        shadow_first_nz   = 0;
        shadow_last_nz    = 0;
        shadow_any_nz     = 1'b0;
        shadow_overflow   = 1'b0;
    endfunction

    function automatic logic [W_W-1:0] index_to_frac(int unsigned k, int unsigned n);
        logic [63:0] q;
        q = (64'(k) << FRAC_W) / n;
        return (q > 64'(FRAC_ONE)) ? FRAC_ONE : q[W_W-1:0];
    endfunction

    // Advance the shadow state by one accepted bin; queue the statistics on the last one
    function automatic void predict_bin(logic [W_W-1:0] w, logic last);
        stats_t      s;
        int unsigned n;
        logic [63:0] q, pos, d, root, cand;
        logic [127:0] acc, sq;
        if (shadow_count < NBINS)
        begin
            shadow_bins[shadow_count] = w;
            shadow_wsum = shadow_wsum + 64'(shadow_count) * 64'(w);
            shadow_runw = shadow_runw + 64'(w);
            if (!shadow_median_hit && shadow_runw >= 64'(shadow_threshold))
            begin
                shadow_median_idx = shadow_count;
                shadow_median_hit = 1'b1;
            end
            if (w != 0)
            begin
                if (!shadow_any_nz)
                begin
                    shadow_first_nz = shadow_count;
                    shadow_any_nz   = 1'b1;
                end
                shadow_last_nz = shadow_count;
            end
            shadow_count++;
        end
        else
            shadow_overflow = 1'b1;
        if (!last)
            return;

        n     = shadow_count;
        s.sat = shadow_overflow;
        q = shadow_wsum / n;
        if (q > 64'(FRAC_ONE))
        begin
            q     = 64'(FRAC_ONE);
            s.sat = 1'b1;
        end
        s.mean      = q[W_W-1:0];
        s.median    = shadow_median_hit ? index_to_frac(shadow_median_idx, n) : '0;
        s.median_ok = shadow_median_hit;

        // Exact weighted sum of squared distances, then integer square root
        acc = '0;
        for (int i = 0; i < int'(shadow_count); i++)
        begin
            pos = 64'(i) << FRAC_W;
            d   = (pos >= shadow_wsum) ? pos - shadow_wsum : shadow_wsum - pos;
            sq  = 128'(d) * 128'(d);
            acc = acc + sq * 128'(shadow_bins[i]);
        end
        root = '0;
        for (int b = 57; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= acc)
                root = cand;
        end
        q = root / (64'(n) * 64'd256);
        if (q > 64'(FRAC_ONE))
        begin
            q     = 64'(FRAC_ONE);
            s.sat = 1'b1;
        end
        s.stddev    = q[W_W-1:0];
        s.low_b     = shadow_any_nz ? index_to_frac(shadow_first_nz, n) : '0;
        s.high_b    = shadow_any_nz ? index_to_frac(shadow_last_nz, n) : '0;
        s.bounds_ok = shadow_any_nz;
        pending_stats.push_back(s);
        clear_shadow();
    endfunction

    task automatic flag_mismatch(string field, logic [W_W-1:0] exp_v, logic [W_W-1:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", field, exp_v, act_v);
    endtask

    // Receiver: stall a random number of cycles per transaction, then compare
    initial
    begin
        stats_t s;
        int     stall;
        res_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = res_burst ? 0 : $urandom_range(0, 14);
            repeat (stall)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
            end
            @(negedge clk);
            res_ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: result transaction with nothing expected");
            end
            else
            begin
                s = pending_stats.pop_front();
                if (mean_frac !== s.mean)
                    flag_mismatch("mean_frac", s.mean, mean_frac);
                if (median_frac !== s.median)
                    flag_mismatch("median_frac", s.median, median_frac);
                if (median_found !== s.median_ok)
                    flag_mismatch("median_found", W_W'(s.median_ok), W_W'(median_found));
                if (stddev_frac !== s.stddev)
                    flag_mismatch("stddev_frac", s.stddev, stddev_frac);
                if (low_bound_frac !== s.low_b)
                    flag_mismatch("low_bound_frac", s.low_b, low_bound_frac);
                if (high_bound_frac !== s.high_b)
                    flag_mismatch("high_bound_frac", s.high_b, high_bound_frac);
                if (bounds_found !== s.bounds_ok)
                    flag_mismatch("bounds_found", W_W'(s.bounds_ok), W_W'(bounds_found));
                if (saturated !== s.sat)
                    flag_mismatch("saturated", W_W'(s.sat), W_W'(saturated));
            end
        end
    end

    // Watchdog: any handshake on any port resets the idle count
    always @(posedge clk)
    begin
        if ((bin_valid && bin_ready) || (res_valid && res_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one bin transaction after a random gap; predict at the accepting edge
    task automatic send_bin(logic [W_W-1:0] w, logic last);
        int gap;
        gap = bin_burst ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            @(negedge clk);
            bin_valid <= 1'b0;
        end
        @(negedge clk);
        bin_valid  <= 1'b1;
        bin_weight <= w;
        last_bin   <= last;
        do
            @(posedge clk);
        while (!bin_ready);
        predict_bin(w, last);
        items_sent++;
    endtask

    // Hold off the sender until every expected result is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        bin_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // APB write of the threshold register, then read it back
    task automatic write_threshold(logic [W_W-1:0] value);
        logic [APB_AW-1:0] addr;
        addr = {REG_THRESHOLD, 2'b00};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[W_W-1:0] !== value)
            flag_mismatch("threshold readback", value, prdata[W_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_threshold = value;
    endtask

    // Weight draw by shape: 0 full range, 1 mostly empty, 2 roughly normalized, 3 full scale
    function automatic logic [W_W-1:0] draw_weight(int shape, int len);
        case (shape)
            0:       return W_W'($urandom_range(0, 65536));
            1:       return ($urandom_range(0, 3) == 0) ? W_W'($urandom_range(1, 65536)) : '0;
            2:       return W_W'($urandom_range(0, (2 * 65536) / len));
            default: return FRAC_ONE;
        endcase
    endfunction

    task automatic send_histogram(int len, int shape);
        for (int i = 0; i < len; i++)
            send_bin(draw_weight(shape, len), i == len - 1);
    endtask

    // Edge cases of a single histogram at the reset threshold
    task automatic test_directed();
        send_bin(FRAC_ONE, 1'b1);               // one full bin
        send_bin('0, 1'b1);                     // one empty bin: no median, no bounds
        send_bin('0, 1'b0);                     // empty then full
        send_bin(FRAC_ONE, 1'b1);
        send_histogram(4, 3);                   // all full: mean and spread clip
        send_bin(17'd1, 1'b0);                  // median never reached
        send_bin('0, 1'b0);
        send_bin(17'd2, 1'b1);
        send_bin('0, 1'b0);                     // bounds in the middle
        send_bin(17'h0AAAA, 1'b0);
        send_bin(17'h15555 & 17'h0FFFF, 1'b0);
        send_bin('0, 1'b1);
        send_histogram(6, 2);
        drain();
    endtask

    // Threshold extremes: zero makes the first bin the median; at 1.0, two bins sum to exactly 1.0
    task automatic test_threshold_extremes();
        write_threshold('0);
        send_bin('0, 1'b0);
        send_bin(17'd5, 1'b1);
        send_histogram(3, 1);
        drain();
        write_threshold(FRAC_ONE);
        send_histogram(3, 2);
        send_bin(17'hFFFF, 1'b0);
        send_bin(17'd1, 1'b1);
        drain();
        write_threshold(THR_RESET);
    endtask

    // Overfill the store; extra bins are dropped and flag saturation
    task automatic test_capacity();
        bin_burst = 1'b1;
        send_histogram(NBINS, 2);
        send_histogram(NBINS + 3, 0);
        bin_burst = 1'b0;
        send_histogram(NBINS + 1, 1);
        drain();
    endtask

    task automatic test_random(int target);
        int len, shape, pick;
        logic [W_W-1:0] thr;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:       thr = '0;
                1:       thr = 17'd1;
                2:       thr = FRAC_ONE;
                3:       thr = 17'hFFFF;
                default: thr = W_W'($urandom_range(0, 65536));
            endcase
            write_threshold(thr);
            for (int h = 0; h < 20; h++)
            begin
                bin_burst = ($urandom_range(0, 7) == 0);
                res_burst = ($urandom_range(0, 7) == 0);
                pick = $urandom_range(0, 19);
                len = (pick < 3) ? 1 : (pick < 17) ? $urandom_range(2, 12) : $urandom_range(13, 40);
                shape = $urandom_range(0, 3);
                send_histogram(len, shape);
            end
            bin_burst = 1'b0;
            res_burst = 1'b0;
            drain();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        bin_valid  = 1'b0;
        bin_weight = '0;
        last_bin   = 1'b0;
        mismatches = 0;
        items_sent = 0;
        idle_cycles = 0;
        bin_burst  = 1'b0;
        res_burst  = 1'b0;
        shadow_threshold = THR_RESET;
        clear_shadow();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_threshold_extremes();
        test_capacity();
        test_random(1350);

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
sv/hs_pkg.sv
sv/hs_div.sv
sv/hs_sqrt.sv
sv/hs_var.sv
sv/histogram_statistics_top.sv
dv/histogram_statistics_top_tb.sv
